// ===== rtl/core/mjd2cal_pkg.sv =====
package mjd2cal_pkg;

    // Input field widths
    localparam int DAY_WIDTH      = 24;
    localparam int FRACTION_WIDTH = 32;

    // Result field widths
    localparam int YEAR_W  = 16;
    localparam int MONTH_W = 4;
    localparam int MDAY_W  = 5;
    localparam int WDAY_W  = 3;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    localparam int IN_BITS   = DAY_WIDTH + FRACTION_WIDTH;
    localparam int OUT_BITS  = YEAR_W + MONTH_W + MDAY_W + WDAY_W + HOUR_W + MIN_W + SEC_W;
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Register stages from input to result
    localparam int NUM_STAGES = 8;

    // Calendar constants
    localparam int GREG_START_MJD = -100840;
    localparam int JDN_OFFSET     = 2400001;
    localparam int YEAR_MIN       = -25000;
    localparam int YEAR_MAX       = 25000;

    // Signed width of the Julian day number and its near relatives
    localparam int CAL_W = ((DAY_WIDTH > 22) ? DAY_WIDTH : 22) + 3;

    // Century term: alpha = floor((4*Z - ALPHA_BIAS) / ALPHA_DIV), biased to stay positive
    localparam int ALPHA_DIV   = 146097;
    localparam int ALPHA_BIAS  = 7468865;
    localparam int ALPHA_OFF   = 1 << (CAL_W - 16);
    localparam int NA_W        = CAL_W + 2;
    localparam int ALPHA_SHIFT = NA_W + 18;
    localparam int QA_W        = NA_W - 17;
    localparam logic [NA_W:0] ALPHA_MUL = (NA_W + 1)'(
        ((64'd1 << ALPHA_SHIFT) + 64'(ALPHA_DIV) - 64'd1) / 64'(ALPHA_DIV));

    // Year term: C = floor((20*B - C_BIAS) / C_DIV), biased to stay positive
    localparam int C_DIV   = 7305;
    localparam int C_BIAS  = 2442;
    localparam int C_OFF   = 1 << (CAL_W - 10);
    localparam int NC_W    = CAL_W + 4;
    localparam int C_SHIFT = NC_W + 13;
    localparam int QC_W    = NC_W - 12;
    localparam int C_W     = QC_W + 1;
    localparam logic [NC_W:0] C_MUL = (NC_W + 1)'(
        ((64'd1 << C_SHIFT) + 64'(C_DIV) - 64'd1) / 64'(C_DIV));

    // Day-of-year and month term: E = floor(10000*(B - D) / E_DIV)
    localparam int D_W     = C_W + 12;
    localparam int X_W     = 9;
    localparam int NE_W    = 23;
    localparam int E_DIV   = 306001;
    localparam int E_SHIFT = NE_W + 19;
    localparam int QE_W    = 5;
    localparam logic [NE_W:0] E_MUL = (NE_W + 1)'(
        ((64'd1 << E_SHIFT) + 64'(E_DIV) - 64'd1) / 64'(E_DIV));

    // floor(30.6001 * e): day count before month term e
    function automatic logic [X_W-1:0] month_start(input logic [3:0] e);
        logic [X_W-1:0] r;
        case (e)
            4'd1:    r = X_W'(30);
            4'd2:    r = X_W'(61);
            4'd3:    r = X_W'(91);
            4'd4:    r = X_W'(122);
            4'd5:    r = X_W'(153);
            4'd6:    r = X_W'(183);
            4'd7:    r = X_W'(214);
            4'd8:    r = X_W'(244);
            4'd9:    r = X_W'(275);
            4'd10:   r = X_W'(306);
            4'd11:   r = X_W'(336);
            4'd12:   r = X_W'(367);
            4'd13:   r = X_W'(397);
            4'd14:   r = X_W'(428);
            4'd15:   r = X_W'(459);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/mjd2cal_date_path.sv =====
module mjd2cal_date_path (
    input  logic                                       aclk,
    input  logic [mjd2cal_pkg::NUM_STAGES-1:0]         stage_load,
    input  logic [mjd2cal_pkg::DAY_WIDTH-1:0]          mjd_day,
    output logic [mjd2cal_pkg::YEAR_W-1:0]             year,
    output logic [mjd2cal_pkg::MONTH_W-1:0]            month,
    output logic [mjd2cal_pkg::MDAY_W-1:0]             day_of_month
);

    localparam int CAL_W = mjd2cal_pkg::CAL_W;
    localparam int NA_W  = mjd2cal_pkg::NA_W;
    localparam int QA_W  = mjd2cal_pkg::QA_W;
    localparam int NC_W  = mjd2cal_pkg::NC_W;
    localparam int QC_W  = mjd2cal_pkg::QC_W;
    localparam int C_W   = mjd2cal_pkg::C_W;
    localparam int D_W   = mjd2cal_pkg::D_W;
    localparam int X_W   = mjd2cal_pkg::X_W;
    localparam int NE_W  = mjd2cal_pkg::NE_W;
    localparam int QE_W  = mjd2cal_pkg::QE_W;
    localparam int DW    = mjd2cal_pkg::DAY_WIDTH;
    localparam int MONTH_W_L = mjd2cal_pkg::MONTH_W;

    localparam logic signed [DW-1:0]  GREG_START = DW'(mjd2cal_pkg::GREG_START_MJD);
    localparam logic signed [C_W-1:0] YEAR_LO    = C_W'(mjd2cal_pkg::YEAR_MIN);
    localparam logic signed [C_W-1:0] YEAR_HI    = C_W'(mjd2cal_pkg::YEAR_MAX);

    // stage 0: Julian day number, calendar select, biased century numerator
    logic signed [CAL_W-1:0] z_next, z0_reg, z1_reg;
    logic                    greg_next, greg0_reg, greg1_reg;
    logic signed [NA_W:0]    alpha_num;
    logic [NA_W-1:0]         na_next, na0_reg;

    // stage 1: century quotient
    logic [2*NA_W:0]         alpha_prod;
    logic [QA_W-1:0]         qa_next, qa1_reg;

    // stage 2: B and biased year numerator
    logic signed [QA_W:0]    alpha;
    logic signed [CAL_W-1:0] a_val, b_next, b2_reg, b3_reg;
    logic signed [CAL_W+4:0] b_ext, c_num;
    logic [NC_W-1:0]         nc_next, nc2_reg;

    // stage 3: year quotient
    logic [2*NC_W:0]         c_prod;
    logic [QC_W-1:0]         qc_next, qc3_reg;

    // stage 4: day count within the year
    logic signed [C_W-1:0]   c_val, c4_reg, c5_reg, c6_reg;
    logic signed [D_W-1:0]   d_prod, d_val, x_full;
    logic [X_W-1:0]          x_next, x4_reg, x5_reg, x6_reg;

    // stage 5: scaled day count
    logic [NE_W-1:0]         ne_next, ne5_reg;

    // stage 6: month term
    logic [2*NE_W:0]         e_prod;
    logic [QE_W-1:0]         qe;
    logic [3:0]              e_next, e6_reg;

    // stage 7: result fields
    logic [MONTH_W_L-1:0]    month_next, month_reg;
    logic signed [C_W-1:0]   year_full;
    logic [mjd2cal_pkg::YEAR_W-1:0] year_next, year_reg;
    logic [mjd2cal_pkg::MDAY_W-1:0] mday_next, mday_reg;
    logic [X_W-1:0]          mday_full;

    always_comb begin
        z_next    = CAL_W'($signed(mjd_day)) + CAL_W'(mjd2cal_pkg::JDN_OFFSET);
        greg_next = ($signed(mjd_day) >= GREG_START);
        alpha_num = ((NA_W + 1)'(z_next) <<< 2)
                  - (NA_W + 1)'(mjd2cal_pkg::ALPHA_BIAS)
                  + (NA_W + 1)'(mjd2cal_pkg::ALPHA_DIV * mjd2cal_pkg::ALPHA_OFF);
        na_next   = alpha_num[NA_W-1:0];
    end

    assign alpha_prod = (2*NA_W + 1)'(na0_reg) * (2*NA_W + 1)'(mjd2cal_pkg::ALPHA_MUL);
    assign qa_next    = alpha_prod[mjd2cal_pkg::ALPHA_SHIFT +: QA_W];

    always_comb begin
        alpha = $signed({1'b0, qa1_reg}) - (QA_W + 1)'(mjd2cal_pkg::ALPHA_OFF);
        if (greg1_reg) begin
            a_val = z1_reg + CAL_W'(1) + CAL_W'(alpha) - CAL_W'(alpha >>> 2);
        end else begin
            a_val = z1_reg;
        end
        b_next  = a_val + CAL_W'(1524);
        b_ext   = (CAL_W + 5)'(b_next);
        c_num   = (b_ext <<< 4) + (b_ext <<< 2)
                - (CAL_W + 5)'(mjd2cal_pkg::C_BIAS)
                + (CAL_W + 5)'(mjd2cal_pkg::C_DIV * mjd2cal_pkg::C_OFF);
        nc_next = c_num[NC_W-1:0];
    end

    assign c_prod  = (2*NC_W + 1)'(nc2_reg) * (2*NC_W + 1)'(mjd2cal_pkg::C_MUL);
    assign qc_next = c_prod[mjd2cal_pkg::C_SHIFT +: QC_W];

    always_comb begin
        c_val  = $signed({1'b0, qc3_reg}) - C_W'(mjd2cal_pkg::C_OFF);
        d_prod = D_W'(c_val) * D_W'(1461);
        d_val  = d_prod >>> 2;
        x_full = D_W'(b3_reg) - d_val;
        x_next = x_full[X_W-1:0];
    end

    assign ne_next = NE_W'(x4_reg) * NE_W'(10000);

    assign e_prod = (2*NE_W + 1)'(ne5_reg) * (2*NE_W + 1)'(mjd2cal_pkg::E_MUL);
    assign qe     = e_prod[mjd2cal_pkg::E_SHIFT +: QE_W];
    assign e_next = qe[3:0];

    always_comb begin
        if (e6_reg < 4'd14) begin
            month_next = e6_reg - 4'd1;
        end else begin
            month_next = e6_reg - 4'd13;
        end
        if (month_next > 4'd2) begin
            year_full = c6_reg - C_W'(4716);
        end else begin
            year_full = c6_reg - C_W'(4715);
        end
        if (year_full < YEAR_LO) begin
            year_next = mjd2cal_pkg::YEAR_W'(YEAR_LO);
        end else if (year_full > YEAR_HI) begin
            year_next = mjd2cal_pkg::YEAR_W'(YEAR_HI);
        end else begin
            year_next = mjd2cal_pkg::YEAR_W'(year_full);
        end
        mday_full = x6_reg - mjd2cal_pkg::month_start(e6_reg);
        mday_next = mday_full[mjd2cal_pkg::MDAY_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_load[0]) begin
            z0_reg    <= z_next;
            greg0_reg <= greg_next;
            na0_reg   <= na_next;
        end
        if (stage_load[1]) begin
            z1_reg    <= z0_reg;
            greg1_reg <= greg0_reg;
            qa1_reg   <= qa_next;
        end
        if (stage_load[2]) begin
            b2_reg  <= b_next;
            nc2_reg <= nc_next;
        end
        if (stage_load[3]) begin
            b3_reg  <= b2_reg;
            qc3_reg <= qc_next;
        end
        if (stage_load[4]) begin
            c4_reg <= c_val;
            x4_reg <= x_next;
        end
        if (stage_load[5]) begin
            c5_reg  <= c4_reg;
            x5_reg  <= x4_reg;
            ne5_reg <= ne_next;
        end
        if (stage_load[6]) begin
            c6_reg <= c5_reg;
            x6_reg <= x5_reg;
            e6_reg <= e_next;
        end
        if (stage_load[7]) begin
            year_reg  <= year_next;
            month_reg <= month_next;
            mday_reg  <= mday_next;
        end
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = mday_reg;

endmodule

// ===== rtl/core/mjd2cal_clock_path.sv =====
module mjd2cal_clock_path (
    input  logic                                       aclk,
    input  logic [mjd2cal_pkg::NUM_STAGES-1:0]         stage_load,
    input  logic [mjd2cal_pkg::DAY_WIDTH-1:0]          mjd_day,
    input  logic [mjd2cal_pkg::FRACTION_WIDTH-1:0]     day_fraction,
    output logic [mjd2cal_pkg::WDAY_W-1:0]             weekday,
    output logic [mjd2cal_pkg::HOUR_W-1:0]             hour,
    output logic [mjd2cal_pkg::MIN_W-1:0]              minute,
    output logic [mjd2cal_pkg::SEC_W-1:0]              second
);

    localparam int FW        = mjd2cal_pkg::FRACTION_WIDTH;
    localparam int DW        = mjd2cal_pkg::DAY_WIDTH;
    localparam int NS        = mjd2cal_pkg::NUM_STAGES;
    localparam int MTOT_W    = 11;
    localparam int STOT_W    = 17;
    localparam int WN_W      = DW + 3;
    localparam int WDIGITS   = (WN_W + 2) / 3;
    localparam int WSUM_W    = 7;
    localparam int TIME_DONE = 2;

    typedef struct packed {
        logic [mjd2cal_pkg::WDAY_W-1:0] weekday;
        logic [mjd2cal_pkg::HOUR_W-1:0] hour;
        logic [mjd2cal_pkg::MIN_W-1:0]  minute;
        logic [mjd2cal_pkg::SEC_W-1:0]  second;
    } clock_fields_t;

    // stage 0: truncated hour, minute and second counts; biased weekday numerator
    logic [FW+4:0]               hour_prod;
    logic [FW+MTOT_W-1:0]        mtot_prod;
    logic [FW+STOT_W-1:0]        stot_prod;
    logic [mjd2cal_pkg::HOUR_W-1:0] hour_next, hour0_reg, hour1_reg;
    logic [MTOT_W-1:0]           mtot_next, mtot0_reg;
    logic [STOT_W-1:0]           stot_next, stot0_reg;
    logic [WN_W-1:0]             wn_next, wn0_reg;

    // stage 1: minute and second; octal digit sum (8 is 1 mod 7)
    logic [MTOT_W-1:0]           min_full;
    logic [STOT_W-1:0]           sec_full;
    logic [mjd2cal_pkg::MIN_W-1:0] min_next, min1_reg;
    logic [mjd2cal_pkg::SEC_W-1:0] sec_next, sec1_reg;
    logic [WDIGITS*3-1:0]        wn_pad;
    logic [WSUM_W-1:0]           wsum_next, wsum1_reg;

    // stage 2: fold the digit sum to 0..6
    logic [4:0]                  wfold;
    logic [mjd2cal_pkg::WDAY_W-1:0] wday_next;
    clock_fields_t               fields_next;
    clock_fields_t               fields_reg [TIME_DONE:NS-1];

    always_comb begin
        hour_prod = (FW + 5)'(day_fraction) * (FW + 5)'(24);
        mtot_prod = (FW + MTOT_W)'(day_fraction) * (FW + MTOT_W)'(1440);
        stot_prod = (FW + STOT_W)'(day_fraction) * (FW + STOT_W)'(86400);
        hour_next = hour_prod[FW +: mjd2cal_pkg::HOUR_W];
        mtot_next = mtot_prod[FW +: MTOT_W];
        stot_next = stot_prod[FW +: STOT_W];
        wn_next   = WN_W'($signed(mjd_day)) + WN_W'(3) + (WN_W'(7) << (DW - 1));
    end

    always_comb begin
        min_full = mtot0_reg - MTOT_W'(hour0_reg) * MTOT_W'(60);
        sec_full = stot0_reg - STOT_W'(mtot0_reg) * STOT_W'(60);
        min_next = min_full[mjd2cal_pkg::MIN_W-1:0];
        sec_next = sec_full[mjd2cal_pkg::SEC_W-1:0];
        wn_pad   = (WDIGITS*3)'(wn0_reg);
        wsum_next = '0;
        for (int i = 0; i < WDIGITS; i++) begin
            wsum_next = wsum_next + WSUM_W'(wn_pad[3*i +: 3]);
        end
    end

    always_comb begin
        wfold = 5'(wsum1_reg[WSUM_W-1:3]) + 5'(wsum1_reg[2:0]);
        if (wfold >= 5'd21) begin
            wday_next = 3'(wfold - 5'd21);
        end else if (wfold >= 5'd14) begin
            wday_next = 3'(wfold - 5'd14);
        end else if (wfold >= 5'd7) begin
            wday_next = 3'(wfold - 5'd7);
        end else begin
            wday_next = 3'(wfold);
        end
        fields_next.weekday = wday_next;
        fields_next.hour    = hour1_reg;
        fields_next.minute  = min1_reg;
        fields_next.second  = sec1_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_load[0]) begin
            hour0_reg <= hour_next;
            mtot0_reg <= mtot_next;
            stot0_reg <= stot_next;
            wn0_reg   <= wn_next;
        end
        if (stage_load[1]) begin
            hour1_reg <= hour0_reg;
            min1_reg  <= min_next;
            sec1_reg  <= sec_next;
            wsum1_reg <= wsum_next;
        end
        if (stage_load[TIME_DONE]) begin
            fields_reg[TIME_DONE] <= fields_next;
        end
        for (int i = TIME_DONE + 1; i < NS; i++) begin
            if (stage_load[i]) begin
                fields_reg[i] <= fields_reg[i-1];
            end
        end
    end

    assign weekday = fields_reg[NS-1].weekday;
    assign hour    = fields_reg[NS-1].hour;
    assign minute  = fields_reg[NS-1].minute;
    assign second  = fields_reg[NS-1].second;

endmodule

// ===== rtl/core/mjd_to_calendar_date_unit.sv =====
// Modified Julian Date to calendar date and time of day. Each request carries a
// signed, floored MJD day number and an unsigned 0.32 fraction of the day; each
// result carries year (astronomical numbering, held to -25000..25000), month,
// day of month, weekday (0 = Sunday) and the hour, minute and second truncated
// from the fraction. Days before MJD -100840 (1582-10-15) follow the Julian
// calendar, that day and later the Gregorian. The block is an eight-stage
// pipeline: one request enters per cycle unless a stall holds the pipeline.
// Every stage has its own valid bit and loads whenever it is empty or
// the next stage takes its item, so bubbles close up and a stall on the result
// side backs up stage by stage; s_tready follows m_tready combinationally
// through that valid chain. The latency is set by the calendar path, whose
// three constant divisions (century, year, month) are each a reciprocal
// multiply in a stage of its own; one add/compare stage sits between the
// century and year divisions, and two (day count within the year, then its
// scaling for the month term) between the year and month divisions, with a
// final stage for month, year clamp and day of month.
module mjd_to_calendar_date_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [23:0] mjd_day, [55:24] day_fraction
    input  logic [mjd2cal_pkg::S_TDATA_W-1:0]      s_tdata,

    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [15:0] year, [19:16] month, [24:20] day_of_month, [27:25] weekday,
    // [32:28] hour, [38:33] minute, [44:39] second, [47:45] zero
    output logic [mjd2cal_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int NS = mjd2cal_pkg::NUM_STAGES;

    logic [NS-1:0] valid_reg, valid_next;
    logic [NS-1:0] stage_load;

    logic [mjd2cal_pkg::DAY_WIDTH-1:0]      mjd_day;
    logic [mjd2cal_pkg::FRACTION_WIDTH-1:0] day_fraction;

    logic [mjd2cal_pkg::YEAR_W-1:0]  year;
    logic [mjd2cal_pkg::MONTH_W-1:0] month;
    logic [mjd2cal_pkg::MDAY_W-1:0]  day_of_month;
    logic [mjd2cal_pkg::WDAY_W-1:0]  weekday;
    logic [mjd2cal_pkg::HOUR_W-1:0]  hour;
    logic [mjd2cal_pkg::MIN_W-1:0]   minute;
    logic [mjd2cal_pkg::SEC_W-1:0]   second;

    // unpack the request
    assign mjd_day      = s_tdata[mjd2cal_pkg::DAY_WIDTH-1:0];
    assign day_fraction = s_tdata[mjd2cal_pkg::DAY_WIDTH +: mjd2cal_pkg::FRACTION_WIDTH];

    // Advance a stage when it is empty or its item moves on; walk back from the output.
    always_comb begin
        stage_load[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            stage_load[i] = !valid_reg[i] || stage_load[i+1];
        end
        valid_next = valid_reg;
        if (stage_load[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int i = 1; i < NS; i++) begin
            if (stage_load[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // year, month and day of month
    mjd2cal_date_path u_date_path (
        .aclk         (aclk),
        .stage_load   (stage_load),
        .mjd_day      (mjd_day),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month)
    );

    // weekday and time of day, delayed to line up with the date
    mjd2cal_clock_path u_clock_path (
        .aclk         (aclk),
        .stage_load   (stage_load),
        .mjd_day      (mjd_day),
        .day_fraction (day_fraction),
        .weekday      (weekday),
        .hour         (hour),
        .minute       (minute),
        .second       (second)
    );

    assign s_tready = stage_load[0];
    assign m_tvalid = valid_reg[NS-1];

    // pack the result, first field lowest, zero fill to whole bytes
    assign m_tdata = mjd2cal_pkg::M_TDATA_W'(
        {second, minute, hour, weekday, day_of_month, month, year});

endmodule
